### rtl/ismu_pkg.sv
// Shared types, constants and helpers for the Ising Metropolis spin-update block.
package ismu_pkg;

    localparam int SIDE_DEF  = 16;

    localparam int COORD_W   = 4;
    localparam int DRAW_W    = 16;
    localparam int THR_W     = 17;
    localparam int DE_W      = 5;
    localparam int EN_W      = 11;
    localparam int MAG_W     = 10;
    localparam int ITEM_W    = 2 * COORD_W + 1 + DRAW_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int RES_W     = 1 + DE_W + EN_W + MAG_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_EIGHT = 1'b1;

    localparam logic [THR_W-1:0] THR_FOUR_RST  = 17'd8869;
    localparam logic [THR_W-1:0] THR_EIGHT_RST = 17'd1200;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ATTEMPT = 1'b1;

    typedef enum logic [1:0] {
        PH_CTR_UP    = 2'd0,
        PH_DOWN_LEFT = 2'd1,
        PH_RIGHT     = 2'd2
    } t_rd_phase;

    typedef struct packed {
        logic      clr_wr;
        logic      load_item;
        t_rd_phase phase;
        logic      cap_first;
        logic      cap_second;
        logic      eval;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_sts;

    // reduce a coordinate modulo the lattice side by repeated subtraction
    function automatic logic [COORD_W-1:0] coord_wrap(input logic [COORD_W-1:0] v,
                                                      input int side);
        logic [COORD_W-1:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            if (int'(r) >= side) begin
                r = r - COORD_W'(side);
            end
        end
        return r;
    endfunction

endpackage

### rtl/ising_metropolis_spin_update.sv
// Top level of the 2-D Ising Metropolis spin-update engine.
//
//  channel  | direction | signals                              | beat contents
//  ---------+-----------+--------------------------------------+------------------------------
//  s        | in        | i_s_tvalid o_s_tready i_s_tdata/user | one load or flip attempt
//  m        | out       | o_m_tvalid i_m_tready o_m_tdata      | flip, dE, energy, magnetization
//  cfg      | in        | i_cfg_we i_cfg_idx i_cfg_wdata       | acceptance threshold write
//
// An item passes through intake, reads of five sites on the two-read-port lattice memory
// in states RD0, RD1 and RD2, and an update step that writes the spin and the totals on a flip.
// After reset a clearing pass sets every spin to +1, one site per cycle; o_s_tready stays
// low until it ends.
// A result waits in the output register; the next item is taken meanwhile and holds
// in its update cycle until the output register is free.
module ising_metropolis_spin_update #(
    parameter int SIDE = ismu_pkg::SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [3:0] site_row, [7:4] site_col, [8] load_spin, [24:9] uniform_draw, rest zero
    input  logic [ismu_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] req_type
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] flipped, [5:1] delta_energy, [16:6] lattice_energy,
    // [26:17] lattice_magnetization, rest zero
    output logic [ismu_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [ismu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ismu_pkg::THR_W-1:0]     i_cfg_wdata
);
    import ismu_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [RES_W-1:0] result;

    ismu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ismu_dpath #(
        .SIDE (SIDE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item_kind (i_s_tuser),
        .i_item_data (i_s_tdata[ITEM_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    assign o_m_tdata = {{(M_TDATA_W-RES_W){1'b0}}, result};

endmodule

### rtl/ismu_ctrl.sv
// Sequencer: clearing pass, item intake, lattice read phases and result hand-off.
module ismu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  ismu_pkg::t_sts i_sts,
    output ismu_pkg::t_cmd o_cmd
);
    import ismu_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD0   = 6'b000100,
        S_RD1   = 6'b001000,
        S_RD2   = 6'b010000,
        S_EVAL  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   eval_go;

    assign eval_go = (r_state == S_EVAL) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.phase = PH_RIGHT;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load_item = i_s_tvalid;
                if (i_s_tvalid) n_state = S_RD0;
            end
            S_RD0: begin
                o_cmd.phase = PH_CTR_UP;
                n_state     = S_RD1;
            end
            S_RD1: begin
                o_cmd.phase     = PH_DOWN_LEFT;
                o_cmd.cap_first = 1'b1;
                n_state         = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_second = 1'b1;
                n_state          = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = eval_go;
                if (eval_go) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (eval_go) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/ismu_dpath.sv
// Datapath: spin memory, thresholds, neighbour sum, acceptance test, running totals.
module ismu_dpath #(
    parameter int SIDE = ismu_pkg::SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ismu_pkg::t_cmd                 i_cmd,
    output ismu_pkg::t_sts                 o_sts,
    input  logic                           i_item_kind,
    input  logic [ismu_pkg::ITEM_W-1:0]    i_item_data,
    input  logic                           i_cfg_we,
    input  logic [ismu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ismu_pkg::THR_W-1:0]     i_cfg_wdata,
    output logic [ismu_pkg::RES_W-1:0]     o_result
);
    import ismu_pkg::*;

    localparam int DEPTH = SIDE * SIDE;
    localparam int RW    = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [RW-1:0] LAST = RW'(SIDE - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] site_addr(input logic [RW-1:0] rr,
                                                input logic [RW-1:0] cc);
        return AW'(AW'(rr) * AW'(SIDE)) + AW'(cc);
    endfunction

    logic             r_mem [DEPTH];
    logic             r_rd_a, r_rd_b;
    logic [AW-1:0]    r_clr_addr;

    logic [THR_W-1:0] r_thr_four, r_thr_eight;
    logic             r_kind, r_load;
    logic [RW-1:0]    r_row, r_col;
    logic [DRAW_W-1:0] r_draw;
    logic             r_s_c, r_n_u, r_n_d, r_n_l;

    logic signed [EN_W-1:0]  r_energy;
    logic signed [MAG_W-1:0] r_mag;

    logic                    r_out_flip;
    logic signed [DE_W-1:0]  r_out_de;
    logic signed [EN_W-1:0]  r_out_en;
    logic signed [MAG_W-1:0] r_out_mag;

    logic [RW-1:0]   row_up, row_dn, col_lf, col_rt;
    logic [AW-1:0]   addr_c, addr_a, addr_b;
    logic [2:0]      n_ones;
    logic signed [DE_W-1:0] de;
    logic            flip;
    logic signed [EN_W-1:0]  n_energy;
    logic signed [MAG_W-1:0] n_mag;

    assign row_up = (r_row == '0)   ? LAST : r_row - RW'(1);
    assign row_dn = (r_row == LAST) ? '0   : r_row + RW'(1);
    assign col_lf = (r_col == '0)   ? LAST : r_col - RW'(1);
    assign col_rt = (r_col == LAST) ? '0   : r_col + RW'(1);
    assign addr_c = site_addr(r_row, r_col);

    always_comb begin
        case (i_cmd.phase)
            PH_CTR_UP: begin
                addr_a = addr_c;
                addr_b = site_addr(row_up, r_col);
            end
            PH_DOWN_LEFT: begin
                addr_a = site_addr(row_dn, r_col);
                addr_b = site_addr(r_row, col_lf);
            end
            default: begin
                addr_a = site_addr(r_row, col_rt);
                addr_b = addr_a;
            end
        endcase
    end

    // lattice memory, two read ports and one write port
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= 1'b1;
        end else if (i_cmd.eval && flip) begin
            r_mem[addr_c] <= ~r_s_c;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr && !o_sts.clr_last) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_four  <= THR_FOUR_RST;
            r_thr_eight <= THR_EIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THR_FOUR:  r_thr_four  <= i_cfg_wdata;
                REG_THR_EIGHT: r_thr_eight <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_item_kind;
            r_row  <= RW'(coord_wrap(i_item_data[COORD_W-1:0], SIDE));
            r_col  <= RW'(coord_wrap(i_item_data[2*COORD_W-1:COORD_W], SIDE));
            r_load <= i_item_data[2*COORD_W];
            r_draw <= i_item_data[ITEM_W-1:2*COORD_W+1];
        end
        if (i_cmd.cap_first) begin
            r_s_c <= r_rd_a;
            r_n_u <= r_rd_b;
        end
        if (i_cmd.cap_second) begin
            r_n_d <= r_rd_a;
            r_n_l <= r_rd_b;
        end
    end

    // right neighbour arrives on port A during the update cycle
    assign n_ones = 3'(r_n_u) + 3'(r_n_d) + 3'(r_n_l) + 3'(r_rd_a);

    always_comb begin
        if (r_s_c) begin
            de = DE_W'({n_ones, 2'b00}) - DE_W'(8);
        end else begin
            de = DE_W'(8) - DE_W'({n_ones, 2'b00});
        end
    end

    always_comb begin
        if (r_kind == REQ_LOAD) begin
            flip = (r_load != r_s_c);
        end else if (de[DE_W-1] || de == '0) begin
            flip = 1'b1;
        end else if (de == DE_W'(4)) begin
            flip = {1'b0, r_draw} < r_thr_four;
        end else begin
            flip = {1'b0, r_draw} < r_thr_eight;
        end
    end

    assign n_energy = r_energy + {{(EN_W-DE_W){de[DE_W-1]}}, de};
    assign n_mag    = r_s_c ? r_mag - MAG_W'(2) : r_mag + MAG_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= EN_W'(-2 * DEPTH);
            r_mag    <= MAG_W'(DEPTH);
        end else if (i_cmd.eval && flip) begin
            r_energy <= n_energy;
            r_mag    <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_flip <= flip;
            r_out_de   <= de;
            r_out_en   <= flip ? n_energy : r_energy;
            r_out_mag  <= flip ? n_mag : r_mag;
        end
    end

    assign o_result = {r_out_mag, r_out_en, r_out_de, r_out_flip};

endmodule
